// File: rtl/one_wire_bus_master_defines.svh
// Assertion macros shared by the one-wire bus master checker.
// Depends on nothing; expects aclk and aresetn in the scope that uses it.
`ifndef ONE_WIRE_BUS_MASTER_DEFINES_SVH
`define ONE_WIRE_BUS_MASTER_DEFINES_SVH

// same-cycle implication
`define OWBM_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("one_wire_bus_master check failed");

// next-cycle implication
`define OWBM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("one_wire_bus_master check failed");

`endif

// File: rtl/owbm_pkg.sv
// Shared types, codes and reset values for the one-wire bus master.
// Depends on nothing; used by every module of the block.
package owbm_pkg;

    localparam int TICK_W    = 10;
    localparam int CFG_IDX_W = 3;
    localparam int BYTE_W    = 8;
    localparam int BIT_IDX_W = 3;

    typedef logic [TICK_W-1:0]    tick_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_RST_LOW,
        PH_RST_WAIT,
        PH_RST_TAIL,
        PH_SLOT_LOW,
        PH_SLOT_REST
    } phase_t;

    typedef enum logic [1:0] {
        CMD_NONE,
        CMD_RESET,
        CMD_WRITE,
        CMD_READ
    } cmd_t;

    localparam cfg_idx_t CFG_RESET_LOW     = 3'd0;
    localparam cfg_idx_t CFG_PRESENCE_WAIT = 3'd1;
    localparam cfg_idx_t CFG_RESET_TAIL    = 3'd2;
    localparam cfg_idx_t CFG_SHORT_LOW     = 3'd3;
    localparam cfg_idx_t CFG_SLOT_REST     = 3'd4;
    localparam cfg_idx_t CFG_ZERO_LOW      = 3'd5;

    localparam tick_t RST_RESET_LOW     = 10'd480;
    localparam tick_t RST_PRESENCE_WAIT = 10'd80;
    localparam tick_t RST_RESET_TAIL    = 10'd400;
    localparam tick_t RST_SHORT_LOW     = 10'd10;
    localparam tick_t RST_SLOT_REST     = 10'd70;
    localparam tick_t RST_ZERO_LOW      = 10'd80;

    typedef struct packed {
        tick_t reset_low;
        tick_t presence_wait;
        tick_t reset_tail;
        tick_t short_low;
        tick_t slot_rest;
        tick_t zero_low;
    } cfg_t;

    typedef struct packed {
        logic [1:0]        mode;
        logic [BYTE_W-1:0] write_byte;
        logic              line_level;
    } item_t;

    typedef struct packed {
        logic              pull_low;
        logic              busy_res;
        logic              done_res;
        logic              presence;
        logic [BYTE_W-1:0] read_byte;
    } result_t;

endpackage

// File: rtl/owbm_cfg_regs.sv
// Timing configuration registers of the one-wire bus master.
// Depends on owbm_pkg.
module owbm_cfg_regs (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_valid,
    input  owbm_pkg::cfg_idx_t cfg_index,
    input  owbm_pkg::tick_t    cfg_data,
    output owbm_pkg::cfg_t     cfg
);

    owbm_pkg::cfg_t cfg_reg;
    owbm_pkg::cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                owbm_pkg::CFG_RESET_LOW:     cfg_next.reset_low     = cfg_data;
                owbm_pkg::CFG_PRESENCE_WAIT: cfg_next.presence_wait = cfg_data;
                owbm_pkg::CFG_RESET_TAIL:    cfg_next.reset_tail    = cfg_data;
                owbm_pkg::CFG_SHORT_LOW:     cfg_next.short_low     = cfg_data;
                owbm_pkg::CFG_SLOT_REST:     cfg_next.slot_rest     = cfg_data;
                owbm_pkg::CFG_ZERO_LOW:      cfg_next.zero_low      = cfg_data;
                default:                     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.reset_low     <= owbm_pkg::RST_RESET_LOW;
            cfg_reg.presence_wait <= owbm_pkg::RST_PRESENCE_WAIT;
            cfg_reg.reset_tail    <= owbm_pkg::RST_RESET_TAIL;
            cfg_reg.short_low     <= owbm_pkg::RST_SHORT_LOW;
            cfg_reg.slot_rest     <= owbm_pkg::RST_SLOT_REST;
            cfg_reg.zero_low      <= owbm_pkg::RST_ZERO_LOW;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: rtl/owbm_in_reg.sv
// Input register: holds one accepted tick until the step logic takes it.
// Depends on owbm_pkg.
module owbm_in_reg (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  owbm_pkg::item_t s_item,
    input  logic            advance,
    output logic            item_valid,
    output owbm_pkg::item_t item
);

    logic            valid_reg;
    logic            valid_next;
    owbm_pkg::item_t item_reg;

    assign s_ready = !valid_reg || advance;

    always_comb begin
        valid_next = valid_reg;
        if (s_ready) begin
            valid_next = s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// File: rtl/owbm_step.sv
// Bus sequencer: phase state machine, tick counter, bit shifter, presence.
// Depends on owbm_pkg; advances one tick per taken item.
module owbm_step (
    input  logic              aclk,
    input  logic              aresetn,
    input  owbm_pkg::cfg_t    cfg,
    input  owbm_pkg::item_t   item,
    input  logic              advance,
    output owbm_pkg::result_t result
);

    localparam int CNT_W = owbm_pkg::TICK_W + 1;

    owbm_pkg::phase_t                      phase_reg, phase_next;
    owbm_pkg::tick_t                       count_reg, count_next;
    logic [owbm_pkg::BIT_IDX_W-1:0]        bit_reg, bit_next;
    logic [owbm_pkg::BYTE_W-1:0]           shift_reg, shift_next;
    owbm_pkg::cmd_t                        kind_reg, kind_next;
    logic                                  presence_reg, presence_next;
    logic [owbm_pkg::BYTE_W-1:0]           read_reg, read_next;

    logic                                  start;
    owbm_pkg::phase_t                      eff_phase;
    owbm_pkg::tick_t                       eff_count;
    logic [owbm_pkg::BIT_IDX_W-1:0]        eff_bit;
    logic [owbm_pkg::BYTE_W-1:0]           eff_shift;
    owbm_pkg::cmd_t                        eff_kind;
    logic                                  cur_bit;
    owbm_pkg::tick_t                       low_len, rest_len, wait_len, cur_len;
    logic [CNT_W-1:0]                      cnt1;
    logic                                  phase_end;
    logic                                  finish;

    function automatic owbm_pkg::tick_t at_least_one(owbm_pkg::tick_t v);
        return (v == '0) ? owbm_pkg::tick_t'(1) : v;
    endfunction

    always_comb begin
        start     = (phase_reg == owbm_pkg::PH_IDLE)
                    && (owbm_pkg::cmd_t'(item.mode) != owbm_pkg::CMD_NONE);
        eff_phase = phase_reg;
        eff_count = count_reg;
        eff_bit   = bit_reg;
        eff_shift = shift_reg;
        eff_kind  = kind_reg;
        if (start) begin
            eff_kind  = owbm_pkg::cmd_t'(item.mode);
            eff_count = '0;
            eff_bit   = '0;
            eff_shift = (eff_kind == owbm_pkg::CMD_WRITE) ? item.write_byte : '0;
            eff_phase = (eff_kind == owbm_pkg::CMD_RESET) ? owbm_pkg::PH_RST_LOW
                                                          : owbm_pkg::PH_SLOT_LOW;
        end
        cur_bit  = eff_shift[eff_bit];
        wait_len = at_least_one(cfg.presence_wait);
        if (eff_kind == owbm_pkg::CMD_WRITE && !cur_bit) begin
            low_len = at_least_one(cfg.zero_low);
        end else begin
            low_len = at_least_one(cfg.short_low);
        end
        if (eff_kind == owbm_pkg::CMD_READ) begin
            rest_len = at_least_one(cfg.slot_rest);
        end else if (!cur_bit) begin
            rest_len = '0;
        end else begin
            rest_len = cfg.slot_rest;
        end
    end

    always_comb begin
        phase_next    = eff_phase;
        count_next    = eff_count;
        bit_next      = eff_bit;
        shift_next    = eff_shift;
        kind_next     = eff_kind;
        presence_next = presence_reg;
        read_next     = read_reg;
        cnt1          = {1'b0, eff_count} + CNT_W'(1);
        finish        = 1'b0;
        phase_end     = 1'b0;
        case (eff_phase)
            owbm_pkg::PH_RST_LOW:   cur_len = at_least_one(cfg.reset_low);
            owbm_pkg::PH_RST_WAIT:  cur_len = wait_len;
            owbm_pkg::PH_RST_TAIL:  cur_len = cfg.reset_tail;
            owbm_pkg::PH_SLOT_LOW:  cur_len = low_len;
            owbm_pkg::PH_SLOT_REST: cur_len = rest_len;
            default:                cur_len = '0;
        endcase
        if (eff_phase != owbm_pkg::PH_IDLE) begin
            if (eff_phase == owbm_pkg::PH_RST_WAIT && cnt1 >= {1'b0, wait_len}) begin
                presence_next = !item.line_level;
            end
            if (eff_phase == owbm_pkg::PH_SLOT_REST && eff_kind == owbm_pkg::CMD_READ
                && eff_count == '0 && item.line_level) begin
                shift_next[eff_bit] = 1'b1;
            end
            phase_end  = cnt1 >= {1'b0, cur_len};
            count_next = phase_end ? '0 : cnt1[owbm_pkg::TICK_W-1:0];
            if (phase_end) begin
                case (eff_phase)
                    owbm_pkg::PH_RST_LOW: begin
                        phase_next = owbm_pkg::PH_RST_WAIT;
                    end
                    owbm_pkg::PH_RST_WAIT: begin
                        if (cfg.reset_tail == '0) begin
                            finish = 1'b1;
                        end else begin
                            phase_next = owbm_pkg::PH_RST_TAIL;
                        end
                    end
                    owbm_pkg::PH_RST_TAIL: begin
                        finish = 1'b1;
                    end
                    owbm_pkg::PH_SLOT_LOW, owbm_pkg::PH_SLOT_REST: begin
                        if (eff_phase == owbm_pkg::PH_SLOT_LOW && rest_len != '0) begin
                            phase_next = owbm_pkg::PH_SLOT_REST;
                        end else if (eff_bit == '1) begin
                            finish = 1'b1;
                        end else begin
                            bit_next   = eff_bit + 1'b1;
                            phase_next = owbm_pkg::PH_SLOT_LOW;
                        end
                    end
                    default: begin
                        phase_next = eff_phase;
                    end
                endcase
            end
            if (finish) begin
                phase_next = owbm_pkg::PH_IDLE;
                if (eff_kind == owbm_pkg::CMD_READ) begin
                    read_next = shift_next;
                end
            end
        end
    end

    always_comb begin
        result.busy_res  = eff_phase != owbm_pkg::PH_IDLE;
        result.pull_low  = eff_phase == owbm_pkg::PH_RST_LOW
                           || eff_phase == owbm_pkg::PH_SLOT_LOW;
        result.done_res  = finish;
        result.presence  = presence_next;
        result.read_byte = read_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= owbm_pkg::PH_IDLE;
            count_reg    <= '0;
            bit_reg      <= '0;
            shift_reg    <= '0;
            kind_reg     <= owbm_pkg::CMD_NONE;
            presence_reg <= 1'b0;
            read_reg     <= '0;
        end else if (advance) begin
            phase_reg    <= phase_next;
            count_reg    <= count_next;
            bit_reg      <= bit_next;
            shift_reg    <= shift_next;
            kind_reg     <= kind_next;
            presence_reg <= presence_next;
            read_reg     <= read_next;
        end
    end

endmodule

// File: rtl/owbm_out_reg.sv
// Result register: holds one tick's outputs until the receiver takes them.
// Depends on owbm_pkg.
module owbm_out_reg (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              load,
    input  owbm_pkg::result_t result,
    output logic              out_free,
    output logic              m_valid,
    input  logic              m_ready,
    output owbm_pkg::result_t m_result
);

    logic              valid_reg;
    logic              valid_next;
    owbm_pkg::result_t result_reg;

    assign out_free = !valid_reg || m_ready;

    always_comb begin
        valid_next = valid_reg;
        if (out_free) begin
            valid_next = load;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            result_reg <= result;
        end
    end

    assign m_valid  = valid_reg;
    assign m_result = result_reg;

endmodule

// File: rtl/one_wire_bus_master.sv
// One-wire bus master, one input transaction per microsecond tick.
// A tick's result passes from the input register through the sequencer step into the result register,
// and the result register can hold it while the receiver stalls.
// Throughput: one tick per cycle while m_ready does not stall the result register.
// Reset: aresetn synchronous active low; sequencer idle, timing registers at
// their defaults, presence and read byte cleared, both channels empty.
module one_wire_bus_master (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  owbm_pkg::cfg_idx_t          cfg_index,
    input  owbm_pkg::tick_t             cfg_data,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [1:0]                  s_mode,
    input  logic [owbm_pkg::BYTE_W-1:0] s_write_byte,
    input  logic                        s_line_level,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic                        m_pull_low,
    output logic                        m_busy_res,
    output logic                        m_done_res,
    output logic                        m_presence,
    output logic [owbm_pkg::BYTE_W-1:0] m_read_byte
);

    owbm_pkg::cfg_t    cfg;
    owbm_pkg::item_t   s_item;
    owbm_pkg::item_t   item;
    owbm_pkg::result_t result;
    owbm_pkg::result_t m_result;
    logic              item_valid;
    logic              out_free;
    logic              advance;

    assign cfg_ready = 1'b1;
    assign advance   = item_valid && out_free;

    assign s_item.mode       = s_mode;
    assign s_item.write_byte = s_write_byte;
    assign s_item.line_level = s_line_level;

    owbm_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    owbm_in_reg u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    owbm_step u_step (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .item    (item),
        .advance (advance),
        .result  (result)
    );

    owbm_out_reg u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (advance),
        .result   (result),
        .out_free (out_free),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_result (m_result)
    );

    assign m_pull_low  = m_result.pull_low;
    assign m_busy_res  = m_result.busy_res;
    assign m_done_res  = m_result.done_res;
    assign m_presence  = m_result.presence;
    assign m_read_byte = m_result.read_byte;

endmodule

// File: rtl/owbm_checker.sv
// Port-level checker for the one-wire bus master, bound to the top level.
// Depends on owbm_pkg and one_wire_bus_master_defines.svh.
`include "one_wire_bus_master_defines.svh"

module owbm_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_ready,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic                        m_pull_low,
    input logic                        m_busy_res,
    input logic                        m_done_res,
    input logic [owbm_pkg::BYTE_W-1:0] m_read_byte
);

    `OWBM_ASSERT_NOW(a_done_busy, m_valid && m_done_res, m_busy_res)
    `OWBM_ASSERT_NOW(a_idle_quiet, m_valid && !m_busy_res, !m_pull_low && !m_done_res)
    `OWBM_ASSERT_NOW(a_empty_ready, !m_valid, s_ready)
    `OWBM_ASSERT_NEXT(a_stall_hold, m_valid && !m_ready, m_valid && $stable(m_read_byte))

endmodule

bind one_wire_bus_master owbm_checker u_checker (.*);

// File: sim/one_wire_bus_master_test.sv
// Self-checking testbench for the one-wire bus master: a directed table, then random ticks
// under several timing settings and idling mixes, checked against a tick model or table rows.
// Depends on owbm_pkg and one_wire_bus_master from the rtl folder.
module one_wire_bus_master_test;
    import owbm_pkg::*;

    typedef struct {
        cmd_t        mode;
        logic [7:0]  wbyte;
        logic        level;
        int          reps;
        bit          typed;
        logic        pull;
        logic        busy;
        logic        done;
        logic        pres;
        logic [7:0]  rbyte;
    } dir_row_t;

    localparam int QUIET_LIMIT = 2000;
    localparam int NUM_PHASES  = 9;
    localparam int HUGE_PHASE  = 5;

    logic        aclk;
    logic        aresetn;
    logic        cfg_valid;
    logic        cfg_ready;
    cfg_idx_t    cfg_index;
    tick_t       cfg_data;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_mode;
    logic [7:0]  s_write_byte;
    logic        s_line_level;
    logic        m_valid;
    logic        m_ready;
    logic        m_pull_low;
    logic        m_busy_res;
    logic        m_done_res;
    logic        m_presence;
    logic [7:0]  m_read_byte;

    bit          tick_typed;
    result_t     tick_want;
    int unsigned gap_pct;
    int unsigned stall_pct;
    int          mismatches;
    int          quiet_cycles;
    result_t     tick_results[$];

    cfg_t        timing = '{RST_RESET_LOW, RST_PRESENCE_WAIT, RST_RESET_TAIL,
                            RST_SHORT_LOW, RST_SLOT_REST, RST_ZERO_LOW};
    phase_t      seq_phase    = PH_IDLE;
    tick_t       seq_count    = '0;
    logic [2:0]  seq_bit      = '0;
    logic [7:0]  seq_shift    = '0;
    cmd_t        seq_cmd      = CMD_NONE;
    logic        seq_presence = 1'b0;
    logic [7:0]  seq_read     = '0;

    dir_row_t dir_tab [10] = '{
        '{CMD_NONE,  8'h00, 1'b1, 1,  1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00},
        '{CMD_RESET, 8'hFF, 1'b0, 1,  1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 8'h00},
        '{CMD_NONE,  8'h00, 1'b0, 1,  1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 8'h00},
        '{CMD_RESET, 8'h00, 1'b1, 1,  1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 8'h00},
        '{CMD_READ,  8'h00, 1'b1, 1,  1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 8'h00},
        '{CMD_WRITE, 8'h5A, 1'b1, 1,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00},
        '{CMD_READ,  8'hFF, 1'b0, 7,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00},
        '{CMD_READ,  8'h00, 1'b1, 1,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00},
        '{CMD_WRITE, 8'h00, 1'b1, 14, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00},
        '{CMD_NONE,  8'h00, 1'b1, 1,  1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 8'hFF}
    };

    one_wire_bus_master DUT (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_mode       (s_mode),
        .s_write_byte (s_write_byte),
        .s_line_level (s_line_level),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_pull_low   (m_pull_low),
        .m_busy_res   (m_busy_res),
        .m_done_res   (m_done_res),
        .m_presence   (m_presence),
        .m_read_byte  (m_read_byte)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    function automatic int unsigned min_one(input tick_t v);
        return (v == '0) ? 1 : int'(v);
    endfunction

    function automatic int unsigned slot_span(input phase_t ph);
        logic cur;
        cur = seq_shift[seq_bit];
        case (ph)
            PH_RST_LOW:  return min_one(timing.reset_low);
            PH_RST_WAIT: return min_one(timing.presence_wait);
            PH_RST_TAIL: return int'(timing.reset_tail);
            PH_SLOT_LOW: begin
                if (seq_cmd == CMD_WRITE && !cur)
                    return min_one(timing.zero_low);
                return min_one(timing.short_low);
            end
            PH_SLOT_REST: begin
                if (seq_cmd == CMD_READ)
                    return min_one(timing.slot_rest);
                if (!cur)
                    return 0;
                return int'(timing.slot_rest);
            end
            default: return 0;
        endcase
    endfunction

    // advance to the next slot; report whether the byte is finished
    function automatic bit next_slot();
        if (seq_bit == 3'd7)
            return 1'b1;
        seq_bit   = seq_bit + 3'd1;
        seq_phase = PH_SLOT_LOW;
        return 1'b0;
    endfunction

    function automatic result_t master_tick(input logic [1:0] mode, input logic [7:0] wbyte,
                                            input logic level);
        result_t     r;
        bit          fin;
        int unsigned c;
        r   = '0;
        fin = 1'b0;
        if (seq_phase == PH_IDLE && mode != CMD_NONE) begin
            seq_cmd   = cmd_t'(mode);
            seq_bit   = '0;
            seq_count = '0;
            seq_shift = (mode == CMD_WRITE) ? wbyte : 8'h00;
            seq_phase = (mode == CMD_RESET) ? PH_RST_LOW : PH_SLOT_LOW;
        end
        if (seq_phase != PH_IDLE) begin
            r.busy_res = 1'b1;
            r.pull_low = (seq_phase == PH_RST_LOW || seq_phase == PH_SLOT_LOW);
            if (seq_phase == PH_RST_WAIT && int'(seq_count) + 1 >= slot_span(PH_RST_WAIT))
                seq_presence = !level;
            if (seq_phase == PH_SLOT_REST && seq_cmd == CMD_READ && seq_count == '0 && level)
                seq_shift[seq_bit] = 1'b1;
            c = int'(seq_count) + 1;
            if (c >= slot_span(seq_phase)) begin
                c = 0;
                case (seq_phase)
                    PH_RST_LOW:  seq_phase = PH_RST_WAIT;
                    PH_RST_WAIT: begin
                        if (timing.reset_tail == '0)
                            fin = 1'b1;
                        else
                            seq_phase = PH_RST_TAIL;
                    end
                    PH_RST_TAIL: fin = 1'b1;
                    PH_SLOT_LOW: begin
                        if (slot_span(PH_SLOT_REST) == 0)
                            fin = next_slot();
                        else
                            seq_phase = PH_SLOT_REST;
                    end
                    default: fin = next_slot();
                endcase
            end
            seq_count = tick_t'(c);
            if (fin) begin
                r.done_res = 1'b1;
                if (seq_cmd == CMD_READ)
                    seq_read = seq_shift;
                seq_phase = PH_IDLE;
            end
        end
        r.presence  = seq_presence;
        r.read_byte = seq_read;
        return r;
    endfunction

    always @(posedge aclk) begin : watch_bus
        result_t got;
        result_t want;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_RESET_LOW:     timing.reset_low     = cfg_data;
                    CFG_PRESENCE_WAIT: timing.presence_wait = cfg_data;
                    CFG_RESET_TAIL:    timing.reset_tail    = cfg_data;
                    CFG_SHORT_LOW:     timing.short_low     = cfg_data;
                    CFG_SLOT_REST:     timing.slot_rest     = cfg_data;
                    CFG_ZERO_LOW:      timing.zero_low      = cfg_data;
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                want = master_tick(s_mode, s_write_byte, s_line_level);
                if (tick_typed)
                    want = tick_want;
                tick_results.push_back(want);
            end
            if (m_valid && m_ready) begin
                got.pull_low  = m_pull_low;
                got.busy_res  = m_busy_res;
                got.done_res  = m_done_res;
                got.presence  = m_presence;
                got.read_byte = m_read_byte;
                if (tick_results.size() == 0) begin
                    if (mismatches < 10)
                        $display("unexpected result: pull=%0d busy=%0d done=%0d pres=%0d rd=%02h",
                                 got.pull_low, got.busy_res, got.done_res, got.presence,
                                 got.read_byte);
                    mismatches++;
                end else begin
                    want = tick_results.pop_front();
                    if (got !== want) begin
                        if (mismatches < 10)
                            $display({"result mismatch: expected pull=%0d busy=%0d done=%0d ",
                                      "pres=%0d rd=%02h, got pull=%0d busy=%0d done=%0d ",
                                      "pres=%0d rd=%02h"},
                                     want.pull_low, want.busy_res, want.done_res,
                                     want.presence, want.read_byte, got.pull_low,
                                     got.busy_res, got.done_res, got.presence, got.read_byte);
                        mismatches++;
                    end
                end
            end
            if ((cfg_valid && cfg_ready) || (s_valid && s_ready) || (m_valid && m_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("one_wire_bus_master test failed");
                $finish;
            end
        end
    end

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    task automatic cfg_write(input cfg_idx_t idx, input tick_t data);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic program_timing(input cfg_t t);
        cfg_write(CFG_RESET_LOW, t.reset_low);
        cfg_write(CFG_PRESENCE_WAIT, t.presence_wait);
        cfg_write(CFG_RESET_TAIL, t.reset_tail);
        cfg_write(CFG_SHORT_LOW, t.short_low);
        cfg_write(CFG_SLOT_REST, t.slot_rest);
        cfg_write(CFG_ZERO_LOW, t.zero_low);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_tick(input logic [1:0] mode, input logic [7:0] wbyte, input logic level,
                             input bit typed, input result_t want);
        @(negedge aclk);
        while ($urandom_range(0, 99) < gap_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid      <= 1'b1;
        s_mode       <= mode;
        s_write_byte <= wbyte;
        s_line_level <= level;
        tick_typed   <= typed;
        tick_want    <= want;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (tick_results.size() != 0)
            @(posedge aclk);
    endtask

    function automatic tick_t pick_ticks();
        int unsigned r;
        r = $urandom_range(0, 7);
        if (r == 0)
            return '0;
        if (r == 7)
            return tick_t'($urandom_range(7, 40));
        return tick_t'(r);
    endfunction

    initial begin : stimulus
        cfg_t        t;
        result_t     want;
        int unsigned pick;
        logic [1:0]  mode;
        aresetn      = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = CFG_RESET_LOW;
        cfg_data     = '0;
        s_valid      = 1'b0;
        s_mode       = CMD_NONE;
        s_write_byte = '0;
        s_line_level = 1'b1;
        m_ready      = 1'b1;
        tick_typed   = 1'b0;
        tick_want    = '0;
        gap_pct      = 0;
        stall_pct    = 0;
        mismatches   = 0;
        quiet_cycles = 0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        program_timing('{default: '0});
        foreach (dir_tab[i]) begin
            want.pull_low  = dir_tab[i].pull;
            want.busy_res  = dir_tab[i].busy;
            want.done_res  = dir_tab[i].done;
            want.presence  = dir_tab[i].pres;
            want.read_byte = dir_tab[i].rbyte;
            repeat (dir_tab[i].reps)
                send_tick(dir_tab[i].mode, dir_tab[i].wbyte, dir_tab[i].level,
                          dir_tab[i].typed, want);
        end
        drain();

        for (int p = 0; p < NUM_PHASES; p++) begin
            if (p == HUGE_PHASE)
                t = '{default: 10'h3FF};
            else
                t = '{pick_ticks(), pick_ticks(), pick_ticks(),
                      pick_ticks(), pick_ticks(), pick_ticks()};
            case (p % 4)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 47; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 47; end
                default: begin gap_pct = 11; stall_pct = 11; end
            endcase
            program_timing(t);
            repeat ((p == HUGE_PHASE) ? 300 : 125) begin
                pick = $urandom_range(0, 9);
                if (pick < 4)
                    mode = CMD_NONE;
                else if (pick < 6)
                    mode = CMD_RESET;
                else if (pick < 8)
                    mode = CMD_WRITE;
                else
                    mode = CMD_READ;
                send_tick(mode, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                          1'b0, '0);
            end
            drain();
        end

        repeat (10) @(posedge aclk);
        if (mismatches == 0)
            $display("one_wire_bus_master test passed");
        else
            $display("one_wire_bus_master test failed");
        $finish;
    end
endmodule
